FILE: sv/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int WSIZE_W         = 7;
    localparam int WINDOW_MAX_DEF  = 64;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    function automatic sample_t max2(input sample_t a, input sample_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: sv/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell (
    input  logic             aclk,
    input  logic             en,
    input  swm_pkg::sample_t sample,
    input  swm_pkg::sample_t prev_max,
    output swm_pkg::sample_t max_q
);

    swm_pkg::sample_t max_reg;

    // max of this sample and the neighbor's run, one sample longer than the neighbor's
    always_ff @(posedge aclk) begin
        if (en) begin
            max_reg <= swm_pkg::max2(sample, prev_max);
        end
    end

    assign max_q = max_reg;

endmodule

FILE: sv/swm_out.sv
`timescale 1ns / 1ps

module swm_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  swm_pkg::sample_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output swm_pkg::sample_t out_data
);

    logic             out_valid_reg;
    swm_pkg::sample_t out_data_reg;
    logic             skid_valid_reg;
    swm_pkg::sample_t skid_data_reg;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_valid) begin
                out_data_reg <= in_data;
            end
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/sliding_window_max.sv
// Streaming maximum filter over signed 32-bit samples.
// Input channel (s_valid/s_ready): one beat carries s_sample and s_restart;
// a set s_restart drops all history and the sample opens a new sequence.
// Result channel (m_valid/m_ready): once the current sequence holds at least
// window_size samples, each input beat yields one beat on m_window_max, the
// greatest of the last window_size samples; earlier beats yield nothing.
// cfg_wr_en/cfg_wr_data write window_size (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX); write it only while the block is idle.
// Each result is registered in the output stage before it is on m_window_max.
// Throughput: one beat per cycle while s_ready is high, set by the WINDOW_MAX
// cells that each fold the new sample into the running max of their neighbor.
// Reset (aresetn low at a clock edge) empties the sequence and the output
// stage and sets window_size to 3.
// When the receiver stalls, the output register and one skid register hold
// results; s_ready drops only when both are full.
`timescale 1ns / 1ps

module sliding_window_max #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [swm_pkg::WSIZE_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_sample,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_window_max
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KW    = (CNT_W > swm_pkg::WSIZE_W) ? CNT_W : swm_pkg::WSIZE_W;

    logic [swm_pkg::WSIZE_W-1:0] window_size_reg;
    logic [CNT_W-1:0]            seen_count_reg;
    logic [CNT_W-1:0]            seen_count_next;
    logic [KW-1:0]               ws_ext;
    logic [KW-1:0]               k_eff;
    logic [IDX_W-1:0]            sel;
    logic                        accept;
    logic                        res_valid;
    logic                        stage_ready;
    swm_pkg::sample_t            res_data;
    swm_pkg::sample_t            cell_q [WINDOW_MAX];

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= swm_pkg::WSIZE_RESET;
        end else if (cfg_wr_en) begin
            window_size_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        ws_ext = KW'(window_size_reg);
        if (ws_ext == '0) begin
            k_eff = KW'(1);
        end else if (ws_ext > KW'(WINDOW_MAX)) begin
            k_eff = KW'(WINDOW_MAX);
        end else begin
            k_eff = ws_ext;
        end
    end

    always_comb begin
        if (s_restart) begin
            seen_count_next = CNT_W'(1);
        end else if (seen_count_reg == CNT_W'(WINDOW_MAX)) begin
            seen_count_next = seen_count_reg;
        end else begin
            seen_count_next = seen_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_count_reg <= '0;
        end else if (accept) begin
            seen_count_reg <= seen_count_next;
        end
    end

    // cell j holds the max of the last j+1 samples
    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        if (j == 0) begin : g_head
            swm_cell u_cell (
                .aclk     (aclk),
                .en       (accept),
                .sample   (s_sample),
                .prev_max (s_sample),
                .max_q    (cell_q[j])
            );
        end else begin : g_body
            swm_cell u_cell (
                .aclk     (aclk),
                .en       (accept),
                .sample   (s_sample),
                .prev_max (cell_q[j-1]),
                .max_q    (cell_q[j])
            );
        end
    end

    assign sel = IDX_W'(k_eff - KW'(2));

    always_comb begin
        if (k_eff == KW'(1)) begin
            res_data = s_sample;
        end else begin
            res_data = swm_pkg::max2(s_sample, cell_q[sel]);
        end
    end

    assign res_valid = accept && (KW'(seen_count_next) >= k_eff);
    assign s_ready   = stage_ready;

    swm_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res_data),
        .in_ready  (stage_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_window_max)
    );

endmodule

FILE: sv/swm_checker.sv
`timescale 1ns / 1ps

module swm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_window_max
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_max))
        else $error("stalled result beat changed");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result beat without input beat");

    a_drain_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready)
        else $error("input still stalled after output drained");

endmodule

bind sliding_window_max swm_checker u_swm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_window_max (m_window_max)
);
